// File: rtl/rspc_pkg.sv
// rspc_pkg: word types, operand and control structs, fixed widths and the
// sequencer state type for the per-column regression score block.
// No dependencies.
`default_nettype none
package rspc_pkg;

   localparam int ACC_W    = 48;
   localparam int SEL_W    = 4;
   localparam int CMP_W    = 3;
   localparam int KNUM_W   = 4;
   localparam int DIV_N_W  = 64;
   localparam int DIV_D_W  = 32;
   localparam int SQ_IN_W  = 64;
   localparam int SQ_OUT_W = 32;

   localparam logic [KNUM_W-1:0] CSR_RESET = 4'd8;
   localparam logic [SEL_W-1:0]  SEL_PROJ  = 4'd0;

   typedef struct packed {
      logic signed [15:0] genotype;
      logic               missing;
      logic signed [15:0] load_0;
      logic signed [15:0] load_1;
      logic signed [15:0] load_2;
      logic signed [15:0] load_3;
      logic signed [15:0] load_4;
      logic signed [15:0] load_5;
      logic signed [15:0] load_6;
      logic signed [15:0] load_7;
      logic               last_sample;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         component;
      logic signed [31:0] score;
      logic               invalid;
      logic               last_score;
   } rsp_word_type;

   typedef struct packed {
      logic               vld;
      logic [SEL_W-1:0]   idx;
      logic signed [15:0] data;
   } op_type;

   typedef struct packed {
      logic [CMP_W-1:0] slot;
      logic [SEL_W-1:0] sel;
   } rd_type;

   typedef struct packed {
      logic              start;
      logic [KNUM_W-1:0] k_num;
   } fin_ctl_type;

   typedef enum logic [4:0] {
      FIN_IDLE, FIN_ZR, FIN_ZZ, FIN_ZZA, FIN_WRD, FIN_WMUL, FIN_WACC, FIN_WZ,
      FIN_WZA, FIN_RSS, FIN_CHK, FIN_DIVV, FIN_GKK, FIN_DEN, FIN_DCHK,
      FIN_SQRT, FIN_DIVS, FIN_OUT, FIN_CLR
   } fin_state_type;

endpackage
`default_nettype wire

// File: rtl/rspc_cell.sv
// rspc_cell: one component cell of the accumulation chain. Holds the
// projection sum and one row of the Gram triangle. Uses rspc_pkg.
`default_nettype none
module rspc_cell #(
   parameter int CELL_IDX = 0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       enable,
   input  wire logic                       clear,
   input  wire logic signed [15:0]         load,
   input  wire rspc_pkg::op_type           op_in,
   output rspc_pkg::op_type                op_out,
   input  wire logic [rspc_pkg::SEL_W-1:0] rd_sel,
   output logic [rspc_pkg::ACC_W-1:0]      rd_data
);
   import rspc_pkg::*;

   localparam int ROW = CELL_IDX + 1;

   op_type                  op_ff;
   logic signed [31:0]      mul_ff;
   logic                    mvld_ff;
   logic [SEL_W-1:0]        midx_ff;
   logic [ACC_W-1:0]        proj_ff;
   logic [ACC_W-1:0]        gram_ff [ROW];
   logic signed [ACC_W-1:0] term;

   assign op_out = op_ff;
   assign term   = ACC_W'(mul_ff) >>> 4;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff.vld <= 1'b0;
         mvld_ff   <= 1'b0;
      end else begin
         op_ff.vld <= op_in.vld;
         mvld_ff   <= op_in.vld & enable;
      end
      op_ff.idx  <= op_in.idx;
      op_ff.data <= op_in.data;
      mul_ff     <= load * op_in.data;
      midx_ff    <= op_in.idx;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         proj_ff <= '0;
         for (int l = 0; l < ROW; l++) gram_ff[l] <= '0;
      end else if (mvld_ff) begin
         if (midx_ff == SEL_PROJ) proj_ff <= proj_ff + term;
         for (int l = 0; l < ROW; l++) begin
            if (midx_ff == SEL_W'(l + 1)) gram_ff[l] <= gram_ff[l] + term;
         end
      end
   end

   always_comb begin
      rd_data = proj_ff;
      for (int l = 0; l < ROW; l++) begin
         if (rd_sel == SEL_W'(l + 1)) rd_data = gram_ff[l];
      end
   end

endmodule
`default_nettype wire

// File: rtl/rspc_div.sv
// rspc_div: restoring unsigned divider, one quotient bit per cycle.
// Uses rspc_pkg widths.
`default_nettype none
module rspc_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [rspc_pkg::DIV_N_W-1:0] num,
   input  wire logic [rspc_pkg::DIV_D_W-1:0] den,
   output logic                              done,
   output logic [rspc_pkg::DIV_N_W-1:0]      quo
);
   import rspc_pkg::*;

   localparam int CNT_W = $clog2(DIV_N_W + 1);

   logic               run_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DIV_D_W:0]   rem_ff;
   logic [DIV_N_W-1:0] quo_ff;
   logic [DIV_D_W-1:0] den_ff;
   logic [DIV_D_W:0]   trial;
   logic               fits;

   assign trial = {rem_ff[DIV_D_W-1:0], quo_ff[DIV_N_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign done  = done_ff;
   assign quo   = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(DIV_N_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (run_ff) begin
         rem_ff <= fits ? trial - {1'b0, den_ff} : trial;
         quo_ff <= {quo_ff[DIV_N_W-2:0], fits};
      end
   end

endmodule
`default_nettype wire

// File: rtl/rspc_sqrt.sv
// rspc_sqrt: bit-pair integer square root, one result bit per cycle.
// Uses rspc_pkg widths.
`default_nettype none
module rspc_sqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [rspc_pkg::SQ_IN_W-1:0] radicand,
   output logic                              done,
   output logic [rspc_pkg::SQ_OUT_W-1:0]     root
);
   import rspc_pkg::*;

   localparam int CNT_W = $clog2(SQ_OUT_W + 1);

   logic               run_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [SQ_IN_W-1:0] v_ff;
   logic [SQ_IN_W-1:0] r_ff;
   logic [SQ_IN_W-1:0] bit_ff;
   logic [SQ_IN_W-1:0] trial;

   assign trial = r_ff + bit_ff;
   assign done  = done_ff;
   assign root  = r_ff[SQ_OUT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(SQ_OUT_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= radicand;
         r_ff   <= '0;
         bit_ff <= SQ_IN_W'(1) << (SQ_IN_W - 2);
      end else if (run_ff) begin
         if (v_ff >= trial) begin
            v_ff <= v_ff - trial;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

endmodule
`default_nettype wire

// File: rtl/rspc_fin.sv
// rspc_fin: end-of-column sequencer. Reads the cell accumulators, forms the
// residual sum and the per-component scores. Uses rspc_pkg, rspc_div, rspc_sqrt.
`default_nettype none
module rspc_fin #(
   parameter int MAX_COMP = 8,
   parameter int CNT_W    = 21
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire rspc_pkg::fin_ctl_type      ctl,
   input  wire logic [CNT_W-1:0]           count,
   input  wire logic [rspc_pkg::ACC_W-1:0] sq_sum,
   output rspc_pkg::rd_type                rd,
   input  wire logic [rspc_pkg::ACC_W-1:0] rd_data,
   output logic                            clear,
   output logic                            busy,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rspc_pkg::rsp_word_type          rsp_word
);
   import rspc_pkg::*;

   localparam logic signed [63:0] ZR_HI = 64'sd8388607;
   localparam logic signed [63:0] ZR_LO = -64'sd8388608;
   localparam logic signed [63:0] I32_HI = 64'sd2147483647;
   localparam logic signed [63:0] I32_LO = -64'sd2147483648;

   function automatic logic signed [23:0] sat_zr(input logic [ACC_W-1:0] a);
      logic signed [63:0] s;
      s = 64'(signed'(a)) >>> 15;
      if (s > ZR_HI) s = ZR_HI;
      if (s < ZR_LO) s = ZR_LO;
      return s[23:0];
   endfunction

   function automatic logic signed [31:0] sat_gr(input logic [ACC_W-1:0] a);
      logic signed [63:0] s;
      s = 64'(signed'(a)) >>> 10;
      if (s > I32_HI) s = I32_HI;
      if (s < I32_LO) s = I32_LO;
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] sat_w(input logic signed [63:0] a);
      logic signed [63:0] s;
      s = a >>> 8;
      if (s > I32_HI) s = I32_HI;
      if (s < -I32_HI) s = -I32_HI;
      return s[31:0];
   endfunction

   fin_state_type      state_ff, state_in;
   logic [CMP_W-1:0]   k_ff, l_ff;
   logic [KNUM_W-1:0]  kq_ff;
   logic signed [23:0] zr_ff [MAX_COMP];
   logic signed [63:0] zz_ff, sum_ff, zgz_ff, rss_ff, prod_ff;
   logic signed [31:0] gr_ff, gkk_ff, v_ff, sc_ff;
   logic               allbad_ff, bad_ff;
   logic               out_vld_ff;
   rsp_word_type       out_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [23:0] zr_k, zr_l;
   logic               k_last, l_last, bad_all, out_load;
   logic               div_start, div_done, sq_start, sq_done;
   logic [DIV_N_W-1:0] div_num, div_quo;
   logic [DIV_D_W-1:0] div_den;
   logic [SQ_OUT_W-1:0] sq_root;
   logic signed [24:0] zr_ext, zr_mag;
   logic signed [63:0] rss_new, q_s, sc_new;
   logic [CMP_W-1:0]   kl_hi, kl_lo;

   always_comb begin
      zr_k = '0;
      zr_l = '0;
      for (int i = 0; i < MAX_COMP; i++) begin
         if (k_ff == CMP_W'(i)) zr_k = zr_ff[i];
         if (l_ff == CMP_W'(i)) zr_l = zr_ff[i];
      end
   end

   assign k_last   = KNUM_W'(k_ff) == kq_ff - 1'b1;
   assign l_last   = KNUM_W'(l_ff) == kq_ff - 1'b1;
   assign kl_hi    = (k_ff > l_ff) ? k_ff : l_ff;
   assign kl_lo    = (k_ff > l_ff) ? l_ff : k_ff;
   assign rss_new  = (64'(signed'(sq_sum)) >>> 4) - (zz_ff <<< 1) + (zgz_ff >>> 8);
   assign bad_all  = (32'(count) <= 32'(kq_ff)) || (rss_ff <= 0);
   assign out_load = (state_ff == FIN_OUT) && (!out_vld_ff || !rsp_stall);
   assign zr_ext   = 25'(zr_k);
   assign zr_mag   = zr_ext[24] ? -zr_ext : zr_ext;
   assign q_s      = signed'(div_quo);

   always_comb begin
      if (!zr_k[23]) sc_new = (q_s > I32_HI) ? I32_HI : q_s;
      else sc_new = (q_s > -I32_LO) ? I32_LO : -q_s;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FIN_IDLE: if (ctl.start) state_in = FIN_ZR;
         FIN_ZR:   state_in = FIN_ZZ;
         FIN_ZZ:   state_in = FIN_ZZA;
         FIN_ZZA:  state_in = k_last ? FIN_WRD : FIN_ZR;
         FIN_WRD:  state_in = FIN_WMUL;
         FIN_WMUL: state_in = FIN_WACC;
         FIN_WACC: state_in = l_last ? FIN_WZ : FIN_WRD;
         FIN_WZ:   state_in = FIN_WZA;
         FIN_WZA:  state_in = k_last ? FIN_RSS : FIN_WRD;
         FIN_RSS:  state_in = FIN_CHK;
         FIN_CHK:  state_in = bad_all ? FIN_OUT : FIN_DIVV;
         FIN_DIVV: if (div_done) state_in = FIN_GKK;
         FIN_GKK:  state_in = FIN_DEN;
         FIN_DEN:  state_in = FIN_DCHK;
         FIN_DCHK: state_in = (gkk_ff <= 0 || v_ff == 0) ? FIN_OUT : FIN_SQRT;
         FIN_SQRT: if (sq_done) state_in = FIN_DIVS;
         FIN_DIVS: if (div_done) state_in = FIN_OUT;
         FIN_OUT: begin
            if (out_load) state_in = k_last ? FIN_CLR : (allbad_ff ? FIN_OUT : FIN_GKK);
         end
         FIN_CLR:  state_in = FIN_IDLE;
         default:  state_in = FIN_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      rd.slot   = k_ff;
      rd.sel    = SEL_PROJ;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      sq_start  = 1'b0;
      clear     = 1'b0;
      busy      = 1'b1;
      case (state_ff)
         FIN_IDLE: busy = 1'b0;
         FIN_ZZ: begin
            mul_a = 32'(zr_k);
            mul_b = 32'(zr_k);
         end
         FIN_WRD: begin
            rd.slot = kl_hi;
            rd.sel  = SEL_W'(kl_lo) + 1'b1;
         end
         FIN_WMUL: begin
            mul_a = gr_ff;
            mul_b = 32'(zr_l);
         end
         FIN_WZ: begin
            mul_a = 32'(zr_k);
            mul_b = sat_w(sum_ff);
         end
         FIN_CHK: begin
            div_start = !bad_all;
            div_num   = unsigned'(rss_ff);
            div_den   = DIV_D_W'(count) - DIV_D_W'(kq_ff);
         end
         FIN_GKK:  rd.sel = SEL_W'(k_ff) + 1'b1;
         FIN_DEN: begin
            mul_a = v_ff;
            mul_b = gkk_ff;
         end
         FIN_DCHK: sq_start = !(gkk_ff <= 0 || v_ff == 0);
         FIN_SQRT: begin
            div_start = sq_done;
            div_num   = DIV_N_W'(unsigned'(zr_mag)) << 24;
            div_den   = sq_root;
         end
         FIN_CLR:  clear = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FIN_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         FIN_IDLE: begin
            k_ff   <= '0;
            l_ff   <= '0;
            zz_ff  <= '0;
            zgz_ff <= '0;
            sum_ff <= '0;
            kq_ff  <= ctl.k_num;
         end
         FIN_ZR: begin
            for (int i = 0; i < MAX_COMP; i++) begin
               if (k_ff == CMP_W'(i)) zr_ff[i] <= sat_zr(rd_data);
            end
         end
         FIN_ZZA: begin
            zz_ff <= zz_ff + prod_ff;
            k_ff  <= k_last ? '0 : k_ff + 1'b1;
         end
         FIN_WRD:  gr_ff <= sat_gr(rd_data);
         FIN_WACC: begin
            sum_ff <= sum_ff + prod_ff;
            if (!l_last) l_ff <= l_ff + 1'b1;
         end
         FIN_WZA: begin
            zgz_ff <= zgz_ff + prod_ff;
            sum_ff <= '0;
            l_ff   <= '0;
            if (!k_last) k_ff <= k_ff + 1'b1;
         end
         FIN_RSS:  rss_ff <= rss_new;
         FIN_CHK: begin
            allbad_ff <= bad_all;
            k_ff      <= '0;
            bad_ff    <= 1'b1;
            sc_ff     <= '0;
         end
         FIN_DIVV: begin
            if (div_done) v_ff <= (q_s > I32_HI) ? I32_HI[31:0] : div_quo[31:0];
         end
         FIN_GKK:  gkk_ff <= sat_gr(rd_data);
         FIN_DCHK: begin
            bad_ff <= 1'b1;
            sc_ff  <= '0;
         end
         FIN_DIVS: begin
            if (div_done) begin
               sc_ff  <= sc_new[31:0];
               bad_ff <= 1'b0;
            end
         end
         FIN_OUT:  if (out_load && !k_last) k_ff <= k_ff + 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (out_load) out_vld_ff <= 1'b1;
      else if (!rsp_stall) out_vld_ff <= 1'b0;
      if (out_load) begin
         out_ff.component  <= k_ff;
         out_ff.score      <= sc_ff;
         out_ff.invalid    <= bad_ff;
         out_ff.last_score <= k_last;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_ff;

   rspc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   rspc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (unsigned'(prod_ff)),
      .done     (sq_done),
      .root     (sq_root)
   );

endmodule
`default_nettype wire

// File: rtl/regression_score_per_column.sv
// regression_score_per_column: top level. Operand injection, square sum and
// count, the component cell chain and the end-of-column sequencer.
// Uses rspc_pkg, rspc_cell, rspc_fin.
//
//  port group   dir   word / width        handshake
//  req_*        in    req_word_type       req_valid / req_stall
//  rsp_*        out   rsp_word_type       rsp_valid / rsp_stall
//  csr_*        in    4-bit K             csr_write_enable
//
// The next sample is not accepted until the current one is through:
// MAX_COMPONENTS+1 operands (x, then each loading) are fed into the cell
// chain one a cycle and ripple through all cells with one multiplier each.
// A last sample then runs the sequencer with the shared multiplier and the
// serial divider. Reset is synchronous and clears all sums. A stalled result
// output holds the sequencer.
`default_nettype none
module regression_score_per_column #(
   parameter int MAX_COMPONENTS = 8,
   parameter int MAX_SAMPLES    = 1048576
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire rspc_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rspc_pkg::rsp_word_type      rsp_word,
   input  wire logic                   csr_write_enable,
   input  wire logic [3:0]             csr_write_data
);
   import rspc_pkg::*;

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int OPS   = MAX_COMPONENTS + 1;
   localparam int DONE  = OPS + MAX_COMPONENTS + 2;
   localparam int CYC_W = $clog2(DONE + 1);

   logic [KNUM_W-1:0]  csr_ff;
   logic [KNUM_W-1:0]  k_num;
   logic               busy_ff;
   logic [CYC_W-1:0]   cyc_ff;
   req_word_type       req_ff;
   logic signed [31:0] sq_mul_ff;
   logic               sq_vld_ff;
   logic [ACC_W-1:0]   sq_ff;
   logic [CNT_W-1:0]   cnt_ff;

   logic               accept, fin_busy, clear;
   logic signed [15:0] loads [8];
   op_type             ops [MAX_COMPONENTS+1];
   logic [ACC_W-1:0]   cell_rd [MAX_COMPONENTS];
   logic [ACC_W-1:0]   rd_data;
   rd_type             rd;
   fin_ctl_type        ctl;

   always_comb begin
      if (csr_ff == '0) k_num = KNUM_W'(1);
      else if (csr_ff > KNUM_W'(MAX_COMPONENTS)) k_num = KNUM_W'(MAX_COMPONENTS);
      else k_num = csr_ff;
   end

   assign req_stall = busy_ff | fin_busy;
   assign accept    = req_valid & ~req_stall;

   assign loads[0] = req_ff.load_0;
   assign loads[1] = req_ff.load_1;
   assign loads[2] = req_ff.load_2;
   assign loads[3] = req_ff.load_3;
   assign loads[4] = req_ff.load_4;
   assign loads[5] = req_ff.load_5;
   assign loads[6] = req_ff.load_6;
   assign loads[7] = req_ff.load_7;

   always_ff @(posedge clock) begin
      if (reset) csr_ff <= CSR_RESET;
      else if (csr_write_enable) csr_ff <= csr_write_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cyc_ff  <= '0;
      end else if (accept) begin
         busy_ff <= 1'b1;
         cyc_ff  <= '0;
      end else if (busy_ff) begin
         cyc_ff <= cyc_ff + 1'b1;
         if (cyc_ff == CYC_W'(DONE)) busy_ff <= 1'b0;
      end
      if (accept) req_ff <= req_word;
   end

   // operand stream: genotype first, then the loadings
   always_comb begin
      ops[0].vld  = busy_ff && !req_ff.missing && (cyc_ff < CYC_W'(OPS));
      ops[0].idx  = SEL_W'(cyc_ff);
      ops[0].data = req_ff.genotype;
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
         if (cyc_ff == CYC_W'(i + 1)) ops[0].data = loads[i];
      end
   end

   always_ff @(posedge clock) begin
      sq_mul_ff <= req_ff.genotype * req_ff.genotype;
      if (reset) sq_vld_ff <= 1'b0;
      else sq_vld_ff <= busy_ff && !req_ff.missing && (cyc_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         sq_ff  <= '0;
         cnt_ff <= '0;
      end else if (sq_vld_ff) begin
         sq_ff <= sq_ff + (ACC_W'(sq_mul_ff) >> 4);
         if (cnt_ff < CNT_W'(MAX_SAMPLES)) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   for (genvar i = 0; i < MAX_COMPONENTS; i++) begin : g_cell
      rspc_cell #(
         .CELL_IDX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (KNUM_W'(i) < k_num),
         .clear   (clear),
         .load    (loads[i]),
         .op_in   (ops[i]),
         .op_out  (ops[i+1]),
         .rd_sel  (rd.sel),
         .rd_data (cell_rd[i])
      );
   end

   always_comb begin
      rd_data = cell_rd[0];
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
         if (rd.slot == CMP_W'(i)) rd_data = cell_rd[i];
      end
   end

   assign ctl.start = busy_ff && (cyc_ff == CYC_W'(DONE)) && req_ff.last_sample;
   assign ctl.k_num = k_num;

   rspc_fin #(
      .MAX_COMP (MAX_COMPONENTS),
      .CNT_W    (CNT_W)
   ) u_fin (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .count     (cnt_ff),
      .sq_sum    (sq_ff),
      .rd        (rd),
      .rd_data   (rd_data),
      .clear     (clear),
      .busy      (fin_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire
